// File: src/dieq_pkg.sv
// ----------------------------------------------------------------------------
// dieq_pkg
// Shared codes, constants and types of the debounced input event queue.
// ----------------------------------------------------------------------------
package dieq_pkg;

  localparam int NUM_INPUTS = 4;
  localparam int EV_W       = 3;
  localparam int REQ_W      = 2;
  localparam int TIME_W     = 32;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = 2;

  // input positions in sampling order
  localparam int IDX_NEEDLE = 3;

  // request codes
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STOP   = 2'd2;

  // event codes
  localparam logic [EV_W-1:0] EV_NONE       = 3'd0;
  localparam logic [EV_W-1:0] EV_STOP       = 3'd1;
  localparam logic [EV_W-1:0] EV_LEFT_DOWN  = 3'd2;
  localparam logic [EV_W-1:0] EV_LEFT_UP    = 3'd3;
  localparam logic [EV_W-1:0] EV_MEASURE    = 3'd4;
  localparam logic [EV_W-1:0] EV_CALIBRATE  = 3'd5;
  localparam logic [EV_W-1:0] EV_NEEDLE_IN  = 3'd6;
  localparam logic [EV_W-1:0] EV_NEEDLE_OUT = 3'd7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_DEBOUNCE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_INSERT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_REMOVE       = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;

  // element k is the code of input k
  localparam logic [NUM_INPUTS-1:0][EV_W-1:0] PRESS_CODES =
    {EV_NEEDLE_IN, EV_CALIBRATE, EV_MEASURE, EV_LEFT_DOWN};
  localparam logic [NUM_INPUTS-1:0][EV_W-1:0] RELEASE_CODES =
    {EV_NEEDLE_OUT, EV_NONE, EV_NONE, EV_LEFT_UP};

  // command kinds between front and back
  localparam logic [1:0] CMD_EVENTS = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_STOP   = 2'd2;

  typedef struct packed {
    logic [1:0]                           kind;
    logic [NUM_INPUTS-1:0]                mask;
    logic [NUM_INPUTS-1:0][EV_W-1:0]      codes;
  } cmd_t;

  typedef struct packed {
    logic ring_empty;
    logic ring_full;
    logic stop_pending;
  } ring_status_t;

endpackage

// File: src/dieq_front.sv
// ----------------------------------------------------------------------------
// dieq_front
// Debounce state of the four inputs and the settle-time registers; turns each
// accepted pop, stop, or input-settling sample into a command for the back end.
// ----------------------------------------------------------------------------
module dieq_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [dieq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dieq_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                               in_fire,
  input  logic [dieq_pkg::REQ_W-1:0]         in_req_type,
  input  logic [dieq_pkg::TIME_W-1:0]        in_now_ms,
  input  logic [dieq_pkg::NUM_INPUTS-1:0]    in_levels,
  output logic                               cmd_push,
  output dieq_pkg::cmd_t                     cmd_data
);
  import dieq_pkg::*;

  logic [CFG_W-1:0] button_ms_r;
  logic [CFG_W-1:0] needle_in_ms_r;
  logic [CFG_W-1:0] needle_out_ms_r;

  logic [NUM_INPUTS-1:0]              raw_r, raw_nxt;
  logic [NUM_INPUTS-1:0]              stable_r, stable_nxt;
  logic [NUM_INPUTS-1:0][TIME_W-1:0]  time_r, time_nxt;

  logic [NUM_INPUTS-1:0][CFG_W-1:0]   settle;
  logic [NUM_INPUTS-1:0][TIME_W-1:0]  elapsed;
  logic [NUM_INPUTS-1:0]              fire;
  logic [NUM_INPUTS-1:0][EV_W-1:0]    codes;
  logic                               sample_go;

  assign sample_go = in_fire && (in_req_type == REQ_SAMPLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      button_ms_r     <= DEBOUNCE_RESET;
      needle_in_ms_r  <= DEBOUNCE_RESET;
      needle_out_ms_r <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BUTTON_DEBOUNCE: button_ms_r     <= cfg_wdata;
        REG_NEEDLE_INSERT:   needle_in_ms_r  <= cfg_wdata;
        REG_NEEDLE_REMOVE:   needle_out_ms_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // four independent debounce comparators
  always_comb begin
    raw_nxt    = raw_r;
    stable_nxt = stable_r;
    time_nxt   = time_r;
    for (int k = 0; k < NUM_INPUTS; k++) begin
      raw_nxt[k]  = in_levels[k];
      time_nxt[k] = (in_levels[k] != raw_r[k]) ? in_now_ms : time_r[k];
      if (k == IDX_NEEDLE) begin
        settle[k] = in_levels[k] ? needle_out_ms_r : needle_in_ms_r;
      end else begin
        settle[k] = button_ms_r;
      end
      elapsed[k] = in_now_ms - time_nxt[k];
      fire[k]    = (in_levels[k] != stable_r[k]) &&
                   (elapsed[k] >= {{(TIME_W-CFG_W){1'b0}}, settle[k]});
      codes[k]   = in_levels[k] ? RELEASE_CODES[k] : PRESS_CODES[k];
      if (fire[k]) begin
        stable_nxt[k] = in_levels[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= '1;
      stable_r <= '1;
      time_r   <= '0;
    end else if (sample_go) begin
      raw_r    <= raw_nxt;
      stable_r <= stable_nxt;
      time_r   <= time_nxt;
    end
  end

  always_comb begin
    cmd_push       = 1'b0;
    cmd_data.kind  = CMD_EVENTS;
    cmd_data.mask  = fire;
    cmd_data.codes = codes;
    if (in_fire) begin
      case (in_req_type)
        REQ_SAMPLE: begin
          cmd_push      = |fire;
          cmd_data.kind = CMD_EVENTS;
        end
        REQ_POP: begin
          cmd_push      = 1'b1;
          cmd_data.kind = CMD_POP;
        end
        REQ_STOP: begin
          cmd_push      = 1'b1;
          cmd_data.kind = CMD_STOP;
        end
        default: cmd_push = 1'b0;
      endcase
    end
  end

endmodule

// File: src/dieq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// dieq_cmd_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module dieq_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dieq_pkg::cmd_t  push_data,
  input  logic            pop,
  output dieq_pkg::cmd_t  head,
  output logic            empty,
  output logic            full
);
  import dieq_pkg::*;

  cmd_t               entries [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r;
  logic [CMDQ_AW-1:0] rd_ptr_r;
  logic [CMDQ_AW:0]   cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign head  = entries[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: src/dieq_back.sv
// ----------------------------------------------------------------------------
// dieq_back
// Executes commands: event ring writes, stop flag and pop results, with a
// registered result stage.
// ----------------------------------------------------------------------------
module dieq_back #(
  parameter int RING_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_valid,
  input  dieq_pkg::cmd_t               cmd,
  output logic                         cmd_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dieq_pkg::EV_W-1:0]    out_event_code,
  output dieq_pkg::ring_status_t       status
);
  import dieq_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] RING_LAST = AW'(RING_DEPTH - 1);

  logic [EV_W-1:0] ring [RING_DEPTH];

  logic [AW-1:0]         wr_idx_r, wr_inc;
  logic [AW-1:0]         rd_idx_r, rd_inc;
  logic                  stop_r, stop_nxt;
  logic [NUM_INPUTS-1:0] done_r, done_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [EV_W-1:0]       out_code_r;

  logic [NUM_INPUTS-1:0] remaining;
  logic [NUM_INPUTS-1:0] pick;
  logic                  last;
  logic [EV_W-1:0]       push_code;
  logic                  push_go;
  logic                  pop_go;
  logic                  ring_we;
  logic                  ring_empty;
  logic                  ring_full;
  logic                  out_free;

  assign wr_inc     = (wr_idx_r == RING_LAST) ? '0 : wr_idx_r + 1'b1;
  assign rd_inc     = (rd_idx_r == RING_LAST) ? '0 : rd_idx_r + 1'b1;
  assign ring_empty = (wr_idx_r == rd_idx_r);
  assign ring_full  = (wr_inc == rd_idx_r);
  assign out_free   = !out_valid_r || out_ready;

  // one event per cycle, lowest input first
  assign remaining = cmd.mask & ~done_r;
  assign pick      = remaining & (~remaining + 1'b1);
  assign last      = (remaining == pick);

  always_comb begin
    push_code = EV_NONE;
    for (int k = 0; k < NUM_INPUTS; k++) begin
      if (pick[k]) begin
        push_code = cmd.codes[k];
      end
    end
  end

  always_comb begin
    cmd_pop  = 1'b0;
    push_go  = 1'b0;
    pop_go   = 1'b0;
    done_nxt = done_r;
    stop_nxt = stop_r;
    if (cmd_valid) begin
      case (cmd.kind)
        CMD_EVENTS: begin
          push_go = |pick;
          if (last) begin
            cmd_pop  = 1'b1;
            done_nxt = '0;
          end else begin
            done_nxt = done_r | pick;
          end
        end
        CMD_POP: begin
          pop_go  = out_free;
          cmd_pop = out_free;
          if (out_free) begin
            stop_nxt = 1'b0;
          end
        end
        CMD_STOP: begin
          cmd_pop  = 1'b1;
          stop_nxt = 1'b1;
        end
        default: cmd_pop = 1'b1;
      endcase
    end
  end

  // full ring drops the event
  assign ring_we = push_go && !ring_full;

  always_comb begin
    if (pop_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[wr_idx_r] <= push_code;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_go) begin
      if (stop_r) begin
        out_code_r <= EV_STOP;
      end else if (ring_empty) begin
        out_code_r <= EV_NONE;
      end else begin
        out_code_r <= ring[rd_idx_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      stop_r      <= 1'b0;
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      stop_r      <= stop_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      if (ring_we) begin
        wr_idx_r <= wr_inc;
      end
      if (pop_go && !stop_r && !ring_empty) begin
        rd_idx_r <= rd_inc;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_event_code      = out_code_r;
  assign status.ring_empty   = ring_empty;
  assign status.ring_full    = ring_full;
  assign status.stop_pending = stop_r;

endmodule

// File: src/debounced_input_event_queue.sv
// ----------------------------------------------------------------------------
// debounced_input_event_queue
// Debounces four active-low inputs against a millisecond timestamp and queues
// the resulting button and needle events for later retrieval.
// ----------------------------------------------------------------------------
// The front end takes one request per cycle and updates the debounce state in
// that cycle; requests then pass through a four-entry command queue to the
// back end. A pop result is loaded into the output register once the pop
// reaches the head of the command queue, provided that register is free or
// being read in that cycle, so an accepted pop meeting an idle back end passes
// through the command queue and the output register before it transfers out.
// The event ring has a single write port, so a sample that settles more than
// one input writes its events one at a time and holds the back end until the
// last is written; a stop is taken at once, a pop as soon as the output
// register is free, and samples that settle nothing or unused request codes
// never reach it. in_ready drops only while the command queue is full. The
// ring holds RING_DEPTH-1 events, further events are dropped, and a pending
// stop is reported ahead of queued events.
module debounced_input_event_queue #(
  parameter int RING_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dieq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dieq_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dieq_pkg::REQ_W-1:0]        in_req_type,
  input  logic [dieq_pkg::TIME_W-1:0]       in_now_ms,
  input  logic                              in_left_level,
  input  logic                              in_measure_level,
  input  logic                              in_calibrate_level,
  input  logic                              in_needle_level,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dieq_pkg::EV_W-1:0]         out_event_code
);
  import dieq_pkg::*;

  logic         in_fire;
  logic         cq_push;
  cmd_t         cq_data;
  cmd_t         cq_head;
  logic         cq_empty;
  logic         cq_full;
  logic         cq_pop;
  ring_status_t ring_status;

  assign cfg_ready = 1'b1;
  assign in_ready  = !cq_full;
  assign in_fire   = in_valid && in_ready;

  dieq_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_fire     (in_fire),
    .in_req_type (in_req_type),
    .in_now_ms   (in_now_ms),
    .in_levels   ({in_needle_level, in_calibrate_level, in_measure_level,
                   in_left_level}),
    .cmd_push    (cq_push),
    .cmd_data    (cq_data)
  );

  dieq_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cq_push),
    .push_data (cq_data),
    .pop       (cq_pop),
    .head      (cq_head),
    .empty     (cq_empty),
    .full      (cq_full)
  );

  dieq_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (!cq_empty),
    .cmd            (cq_head),
    .cmd_pop        (cq_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_code (out_event_code),
    .status         (ring_status)
  );

  // front never writes a full command queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cq_push |-> !cq_full)
    else $error("command pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cq_pop |-> !cq_empty)
    else $error("command popped from empty queue");

  a_ring_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(ring_status.ring_empty && ring_status.ring_full))
    else $error("event ring both empty and full");

  // a stop command always leaves the flag set
  a_stop_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (cq_pop && (cq_head.kind == CMD_STOP)) |=> ring_status.stop_pending)
    else $error("stop command did not set pending flag");

endmodule
